@@ rtl/core/miller_rabin_round_macros.svh @@
// ----------------------------------------------------------------------------
// Miller-Rabin round assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_ROUND_MACROS_SVH
`define MILLER_RABIN_ROUND_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MRR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin round package
// Widths, operand types, unit command and response structs and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrr_pkg;

	localparam int FIELD_W  = 62;
	localparam int NUM_BITS = 62;
	localparam int CNT_W    = $clog2(NUM_BITS);

	typedef logic [FIELD_W-1:0]  field_t;
	typedef logic [NUM_BITS-1:0] val_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic {
		MM_MUL,
		MM_RED
	} mm_op_t;

	typedef struct packed {
		logic   start;
		mm_op_t op;
		val_t   a;
		val_t   b;
		val_t   m;
	} mm_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		val_t result;
	} mm_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_STRIP,
		ST_RED_WAIT,
		ST_POW_CHK,
		ST_MUL_WAIT,
		ST_SQB_WAIT,
		ST_SQ_CHK,
		ST_SQ_WAIT,
		ST_FINISH
	} mrr_state_t;

endpackage

@@ rtl/core/mrr_req_if.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin request channel
// Valid/ready channel carrying the candidate and the random word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrr_req_if;
	import mrr_pkg::*;

	logic   valid;
	logic   ready;
	field_t candidate;
	field_t random_word;

	modport source (output valid, output candidate, output random_word, input ready);
	modport sink (input valid, input candidate, input random_word, output ready);

endinterface

@@ rtl/core/mrr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin response channel
// Valid/ready channel carrying the verdict of one round.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrr_rsp_if;
	logic valid;
	logic ready;
	logic probably_prime;

	modport source (output valid, output probably_prime, input ready);
	modport sink (input valid, input probably_prime, output ready);

endinterface

@@ rtl/core/mrr_modmul.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin modular unit
// Bit-serial modular multiply (LSB first, shift-add) and modular reduction
// (MSB first, restoring), one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_round_macros.svh"

module mrr_modmul (
	input  logic             clk,
	input  logic             arst_n,
	input  mrr_pkg::mm_cmd_t cmd,
	output mrr_pkg::mm_rsp_t rsp
);
	import mrr_pkg::*;

	logic   busy_q;
	logic   done_q;
	mm_op_t op_q;
	val_t   a_q;
	val_t   b_q;
	val_t   m_q;
	val_t   acc_q;
	cnt_t   cnt_q;

	logic [NUM_BITS:0] m_ext;
	logic [NUM_BITS:0] sum;
	logic [NUM_BITS:0] dbl;
	logic [NUM_BITS:0] sh;
	val_t              sum_r;
	val_t              dbl_r;
	val_t              sh_r;
	logic              last;

	assign m_ext = {1'b0, m_q};
	assign sum   = {1'b0, acc_q} + {1'b0, a_q};
	assign dbl   = {a_q, 1'b0};
	assign sh    = {acc_q, b_q[NUM_BITS-1]};
	assign sum_r = (sum >= m_ext) ? val_t'(sum - m_ext) : sum[NUM_BITS-1:0];
	assign dbl_r = (dbl >= m_ext) ? val_t'(dbl - m_ext) : dbl[NUM_BITS-1:0];
	assign sh_r  = (sh >= m_ext) ? val_t'(sh - m_ext) : sh[NUM_BITS-1:0];
	assign last  = (cnt_q == cnt_t'(NUM_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + cnt_t'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			a_q   <= cmd.a;
			b_q   <= cmd.b;
			m_q   <= cmd.m;
			acc_q <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				MM_MUL: begin
					if (b_q[0]) begin
						acc_q <= sum_r;
					end
					a_q <= dbl_r;
					b_q <= b_q >> 1;
				end
				MM_RED: begin
					acc_q <= sh_r;
					b_q   <= b_q << 1;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

	`MRR_ASSERT_SAME(a_start_idle, cmd.start, !busy_q, "Unit started while busy.")
	`MRR_ASSERT_SAME(a_acc_reduced, busy_q, acc_q < m_q, "Accumulator left its residue range.")
	`MRR_ASSERT_SAME(a_done_after_busy, done_q, $past(busy_q), "Done without a preceding step.")

endmodule

@@ rtl/core/miller_rabin_round.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin round
// One witness round of the Miller-Rabin test on a candidate below 2^62.
//
// Usage: an item on req carries candidate and random_word; one item on rsp
// carries probably_prime for it. Both channels use valid/ready and move an
// item when both are high at a clock edge. A new request is taken only when
// the sequencer is idle, one item at a time.
// Flow: two, values below two and even values are decided at classification.
// For an odd candidate, with n-1 = u * 2^t and u of L bits, the block strips
// the t factors of two one at a time, then runs one reduction and up to
// 2L + t modular multiplies in the bit-serial modular unit (one multiplier
// bit per cycle).
// Reset clears the sequencer and drops any waiting result. A stalled
// receiver holds the result in the output register; the next request can be
// taken meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_round_macros.svh"

module miller_rabin_round (
	input logic        clk,
	input logic        arst_n,
	mrr_req_if.sink    req,
	mrr_rsp_if.source  rsp
);
	import mrr_pkg::*;

	mrr_state_t state_q;
	mrr_state_t state_d;

	val_t n_q;
	val_t r_q;
	val_t e_q;
	val_t acc_q;
	val_t base_q;
	cnt_t twos_q;
	logic res_q;
	logic out_valid_q;
	logic prob_q;

	mm_cmd_t mm_cmd;
	mm_rsp_t mm_rsp;

	logic special;
	logic special_res;
	logic nontrivial;
	logic out_load;

	mrr_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mm_cmd),
		.rsp    (mm_rsp)
	);

	assign special     = (n_q < val_t'(2)) || !n_q[0];
	assign special_res = (n_q == val_t'(2));
	assign nontrivial  = (mm_rsp.result == val_t'(1)) && (acc_q != val_t'(1)) &&
		(acc_q != n_q - val_t'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				state_d = (special || special_res) ? ST_FINISH : ST_STRIP;
			end
			ST_STRIP: begin
				if (e_q[0]) state_d = ST_RED_WAIT;
			end
			ST_RED_WAIT: begin
				if (mm_rsp.done) state_d = ST_POW_CHK;
			end
			ST_POW_CHK: begin
				priority if (e_q == '0) state_d = ST_SQ_CHK;
				else if (e_q[0]) state_d = ST_MUL_WAIT;
				else state_d = ST_SQB_WAIT;
			end
			ST_MUL_WAIT: begin
				if (mm_rsp.done) state_d = ST_SQB_WAIT;
			end
			ST_SQB_WAIT: begin
				if (mm_rsp.done) state_d = ST_POW_CHK;
			end
			ST_SQ_CHK: begin
				state_d = (twos_q == '0) ? ST_FINISH : ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (mm_rsp.done) state_d = nontrivial ? ST_FINISH : ST_SQ_CHK;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mm_cmd.start = 1'b0;
		mm_cmd.op    = MM_MUL;
		mm_cmd.a     = acc_q;
		mm_cmd.b     = acc_q;
		mm_cmd.m     = n_q;
		req.ready    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_STRIP: begin
				if (e_q[0]) begin
					mm_cmd.start = 1'b1;
					mm_cmd.op    = MM_RED;
					mm_cmd.a     = '0;
					mm_cmd.b     = r_q;
					mm_cmd.m     = n_q - val_t'(2);
				end
			end
			ST_POW_CHK: begin
				if (e_q != '0) begin
					mm_cmd.start = 1'b1;
					mm_cmd.a     = e_q[0] ? acc_q : base_q;
					mm_cmd.b     = base_q;
				end
			end
			ST_MUL_WAIT: begin
				if (mm_rsp.done) begin
					mm_cmd.start = 1'b1;
					mm_cmd.a     = base_q;
					mm_cmd.b     = base_q;
				end
			end
			ST_SQ_CHK: begin
				mm_cmd.start = (twos_q != '0);
			end
			ST_FINISH: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			prob_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					n_q    <= req.candidate[NUM_BITS-1:0];
					r_q    <= req.random_word[NUM_BITS-1:0];
					e_q    <= req.candidate[NUM_BITS-1:0] - val_t'(1);
					twos_q <= '0;
				end
			end
			ST_CLASSIFY: begin
				res_q <= special_res;
			end
			ST_STRIP: begin
				if (!e_q[0]) begin
					e_q    <= e_q >> 1;
					twos_q <= twos_q + cnt_t'(1);
				end
			end
			ST_RED_WAIT: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.result + val_t'(2);
					acc_q  <= val_t'(1);
				end
			end
			ST_MUL_WAIT: begin
				if (mm_rsp.done) acc_q <= mm_rsp.result;
			end
			ST_SQB_WAIT: begin
				if (mm_rsp.done) begin
					base_q <= mm_rsp.result;
					e_q    <= e_q >> 1;
				end
			end
			ST_SQ_CHK: begin
				if (twos_q == '0) res_q <= (acc_q == val_t'(1));
			end
			ST_SQ_WAIT: begin
				if (mm_rsp.done) begin
					if (nontrivial) begin
						res_q <= 1'b0;
					end else begin
						acc_q  <= mm_rsp.result;
						twos_q <= twos_q - cnt_t'(1);
					end
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.probably_prime = prob_q;

	`MRR_ASSERT_NEXT(a_accept_classify, req.valid && req.ready, state_q == ST_CLASSIFY, "Accepted item not classified next.")
	`MRR_ASSERT_SAME(a_square_count, state_q == ST_SQ_WAIT, twos_q != '0, "Squaring with no squarings left.")
	`MRR_ASSERT_SAME(a_pow_residues, state_q == ST_POW_CHK, (acc_q < n_q) && (base_q < n_q), "Power operands not reduced.")

endmodule

@@ sim/mrr_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin round verdict checker
// Watches the request and response channels of the round block. For every
// accepted request it works out the verdict of one witness round on its own
// and queues it; every accepted response is compared with the oldest queued
// verdict. It reports mismatches and the number of rounds still in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrr_verdict_checker
	import mrr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	input  logic   req_ready,
	input  field_t candidate,
	input  field_t random_word,
	input  logic   rsp_valid,
	input  logic   rsp_ready,
	input  logic   probably_prime,
	output int     errors,
	output int     pending
);

	typedef struct {
		field_t candidate;
		field_t random_word;
		logic   verdict;
	} round_t;

	round_t rounds_in_flight[$];

	function automatic logic [63:0] mul_mod_shift(logic [63:0] x, logic [63:0] y,
			logic [63:0] m);
		logic [63:0] acc;
		acc = '0;
		while (y != 0) begin
			if (y[0])
				acc = (acc + x) % m;
			x = (x << 1) % m;
			y = y >> 1;
		end
		return acc;
	endfunction

	function automatic logic [63:0] pow_mod_square(logic [63:0] base, logic [63:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		while (e != 0) begin
			if (e[0])
				acc = mul_mod_shift(acc, base, m);
			base = mul_mod_shift(base, base, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic round_verdict(val_t cand, val_t word);
		logic [63:0] n;
		logic [63:0] odd;
		logic [63:0] a;
		logic [63:0] prev;
		int          twos;
		int          j;
		n = 64'(cand);
		if (n == 64'd2)
			return 1'b1;
		if (n < 64'd2 || !n[0])
			return 1'b0;
		odd = n - 64'd1;
		twos = 0;
		while (!odd[0]) begin
			odd = odd >> 1;
			twos++;
		end
		a = (64'(word) % (n - 64'd2)) + 64'd2;
		a = pow_mod_square(a, odd, n);
		prev = a;
		for (j = 0; j < twos; j++) begin
			a = mul_mod_shift(a, a, n);
			if (a == 64'd1 && prev != 64'd1 && prev != n - 64'd1)
				return 1'b0;
			prev = a;
		end
		return (a == 64'd1);
	endfunction

	always @(posedge clk) begin
		round_t head;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rounds_in_flight.size() == 0) begin
					if (errors < 10)
						$display("%t: result probably_prime=%0b with no item outstanding",
							$realtime, probably_prime);
					errors = errors + 1;
				end else begin
					head = rounds_in_flight.pop_front();
					if (probably_prime !== head.verdict) begin
						if (errors < 10)
							$display("%t: candidate=%0d random_word=%0d expected %0b got %0b",
								$realtime, head.candidate, head.random_word,
								head.verdict, probably_prime);
						errors = errors + 1;
					end
				end
			end
			if (req_valid && req_ready)
				rounds_in_flight.push_back('{candidate, random_word,
					round_verdict(candidate, random_word)});
			pending = rounds_in_flight.size();
		end
	end

endmodule

@@ sim/tb_miller_rabin_round.sv @@
// ----------------------------------------------------------------------------
// Miller-Rabin round testbench
// Drives candidates and random words into the round block: a directed set of
// edge values, primes and strong pseudoprimes, then random odd candidates of
// mixed sizes with some noise. Both sides idle in random bursts, the receiver
// once holds off long enough to stall the input, and the checker compares
// every verdict against its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_miller_rabin_round;
	import mrr_pkg::*;

	localparam field_t FIELD_MAX = {FIELD_W{1'b1}};
	localparam int     NOTABLE_N = 10;
	localparam field_t NOTABLE [NOTABLE_N] = '{
		62'd3, 62'd341, 62'd561, 62'd2047, 62'd25326001, 62'd3215031751,
		62'd1000000007, 62'd4294967291, 62'd2305843009213693951,
		62'd4611686018427387847
	};

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   gaps_on;
	bit   stalls_on;
	int   hold_left;
	int   stall_left;

	mrr_req_if req ();
	mrr_rsp_if rsp ();

	miller_rabin_round DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mrr_verdict_checker verdict_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.candidate      (req.candidate),
		.random_word    (req.random_word),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.probably_prime (rsp.probably_prime),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic field_t random_field();
		return field_t'({$urandom, $urandom});
	endfunction

	function automatic field_t odd_of_width(int bits);
		field_t c;
		c = random_field() & ((field_t'(1) << bits) - field_t'(1));
		c[0] = 1'b1;
		c[bits-1] = 1'b1;
		return c;
	endfunction

	function automatic field_t random_candidate();
		int     sel;
		field_t c;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			c = random_field();
			if (sel < 12)
				c[0] = 1'b1;
		end else if (sel < 80) begin
			c = odd_of_width($urandom_range(2, 61));
		end else if (sel < 90) begin
			c = NOTABLE[$urandom_range(0, NOTABLE_N - 1)];
		end else if (sel < 95) begin
			c = random_field();
			c[0] = 1'b0;
		end else begin
			c = field_t'($urandom_range(0, 3));
		end
		return c;
	endfunction

	task automatic send_item(input field_t cand, input field_t word);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.candidate <= cand;
		req.random_word <= word;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	initial begin
		req.valid = 1'b0;
		req.candidate = '0;
		req.random_word = '0;
		arst_n = 1'b0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_left = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		send_item('0, '0);
		send_item(62'd1, FIELD_MAX);
		send_item(62'd2, FIELD_MAX);
		send_item(62'd4, random_field());
		send_item(FIELD_MAX - 62'd1, random_field());
		send_item(62'd3, '0);
		send_item(62'd3, FIELD_MAX);
		send_item(62'd5, '0);
		send_item(62'd9, 62'd7);
		send_item(62'd9, 62'd5);
		send_item(62'd97, 62'd94);
		send_item(62'd91, 62'd88);
		send_item(62'd2047, '0);
		send_item(62'd2047, 62'd1);
		send_item(62'd561, random_field());
		send_item(62'd341, '0);
		send_item(62'd25326001, '0);
		send_item(62'd3215031751, 62'd1);
		send_item(62'd2305843009213693951, random_field());
		send_item(62'd4611686018427387847, FIELD_MAX);
		send_item(62'd4611686018427387847, '0);
		send_item(FIELD_MAX, FIELD_MAX);

		repeat (30)
			send_item(random_candidate(), random_field());

		hold_left = 8000;
		repeat (4)
			send_item(odd_of_width($urandom_range(3, 6)), random_field());
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		repeat (30)
			send_item(random_candidate(), random_field());

		gaps_on = 1'b0;
		stalls_on = 1'b0;
		repeat (20)
			send_item(random_candidate(), random_field());
		@(negedge clk);
		req.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
